FILE: rtl/cca_pkg.sv
package cca_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int MICRO_W = 20;

   localparam int OP_W    = 2;
   localparam int REQ_W   = 120;
   localparam int RSP_W   = 64;

   // running carry value and the widest divisor
   localparam int ACC_W   = 33;
   localparam int DVSR_W  = 20;

   // reciprocal divider: floor(x / (d << p)) == (((x >> p) * m) >> k) for every 33-bit x
   localparam int MUL_A_W = 31;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 63;

   localparam logic [MUL_B_W-1:0] RECIP_US   = 32'd140737489;
   localparam int                 US_PRE     = 6;
   localparam int                 US_POST    = 41;
   localparam logic [MUL_B_W-1:0] RECIP_SEC  = 32'd2290649225;
   localparam int                 SEC_PRE    = 2;
   localparam int                 SEC_POST   = 35;
   localparam logic [MUL_B_W-1:0] RECIP_HOUR = 32'd1431655766;
   localparam int                 HOUR_PRE   = 3;
   localparam int                 HOUR_POST  = 32;

   localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1970;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR   = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN   = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP   = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV   = 4'd11;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_LAST    = 5'd31;
   localparam logic [HOUR_W-1:0]  HOUR_LAST   = 5'd23;
   localparam logic [MIN_W-1:0]   MIN_LAST    = 6'd59;
   localparam logic [SEC_W-1:0]   SEC_LAST    = 6'd59;
   localparam logic [MICRO_W-1:0] MICRO_LAST  = 20'd999999;

   localparam logic [DVSR_W-1:0]  MICRO_PER_SEC = 20'd1000000;
   localparam logic [DVSR_W-1:0]  SEC_PER_MIN   = 20'd60;
   localparam logic [DVSR_W-1:0]  MIN_PER_HOUR  = 20'd60;
   localparam logic [DVSR_W-1:0]  HOUR_PER_DAY  = 20'd24;

   // floor(y / 25) == (y * 5243) >> 17 for every 14-bit year
   localparam int                RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_25   = 13'd5243;
   localparam int                RECIP_SHIFT = 17;
   localparam int                QUO25_W     = 10;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_MICRO = 2'd1,
      OP_SEC   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      DIV_US,
      DIV_SEC,
      DIV_MIN,
      DIV_HOUR
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_US_GO,
      ST_US_WAIT,
      ST_SEC_GO,
      ST_SEC_WAIT,
      ST_MIN_GO,
      ST_MIN_WAIT,
      ST_HOUR_GO,
      ST_HOUR_WAIT,
      ST_MONTH,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        load;
      logic        acc_init;
      logic        div_start;
      logic        div_take;
      div_sel_type div_sel;
      logic        month_step;
      logic        month_end;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   div_done;
      logic   month_more;
      logic   month_sat;
   } sts_type;

   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [YEAR_W+RECIP_W-1:0] prod;
      logic [QUO25_W-1:0]        q;
      logic [YEAR_W-1:0]         r;
      logic                      div25;
      prod  = y * RECIP_25;
      q     = prod[RECIP_SHIFT +: QUO25_W];
      r     = y - ({q, 4'b0000} + {1'b0, q, 3'b000} + {4'b0000, q});
      div25 = (r == '0);
      return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0]  y,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      case (m)
         MONTH_FEB: d = leap_year(y) ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/cca_div.sv
module cca_div
   import cca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACC_W-1:0]  dividend,
   input  div_sel_type       sel,
   output logic              done,
   output logic [ACC_W-1:0]  quotient,
   output logic [DVSR_W-1:0] remainder
);

   logic               mul_go_ff, mul_go_in;
   logic               sub_go_ff, sub_go_in;
   logic               done_ff, done_in;
   div_sel_type        sel_ff, sel_in;
   logic [ACC_W-1:0]   num_ff, num_in;
   logic [MUL_P_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]   quo_ff, quo_in;
   logic [DVSR_W-1:0]  rem_ff, rem_in;

   logic [MUL_A_W-1:0] scaled;
   logic [MUL_B_W-1:0] recip;
   logic [DVSR_W-1:0]  dvsr;
   logic [ACC_W-1:0]   quo_est;
   logic [ACC_W-1:0]   back;
   logic [ACC_W-1:0]   diff;

   // pre-shift, reciprocal multiply, then back-multiply for the remainder
   always_comb begin
      case (sel_ff)
         DIV_SEC, DIV_MIN: begin
            scaled  = MUL_A_W'(num_ff[ACC_W-1:SEC_PRE]);
            recip   = RECIP_SEC;
            dvsr    = SEC_PER_MIN;
            quo_est = ACC_W'(prod_ff[MUL_P_W-1:SEC_POST]);
         end
         DIV_HOUR: begin
            scaled  = MUL_A_W'(num_ff[ACC_W-1:HOUR_PRE]);
            recip   = RECIP_HOUR;
            dvsr    = HOUR_PER_DAY;
            quo_est = ACC_W'(prod_ff[MUL_P_W-1:HOUR_POST]);
         end
         default: begin
            scaled  = MUL_A_W'(num_ff[ACC_W-1:US_PRE]);
            recip   = RECIP_US;
            dvsr    = MICRO_PER_SEC;
            quo_est = ACC_W'(prod_ff[MUL_P_W-1:US_POST]);
         end
      endcase
      back = quo_est * ACC_W'(dvsr);
      diff = num_ff - back;
   end

   assign mul_go_in = start;
   assign sub_go_in = mul_go_ff;
   assign done_in   = sub_go_ff;

   always_comb begin
      sel_in  = sel_ff;
      num_in  = num_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         sel_in = sel;
         num_in = dividend;
      end
      if (mul_go_ff) begin
         prod_in = MUL_P_W'(scaled) * MUL_P_W'(recip);
      end
      if (sub_go_ff) begin
         quo_in = quo_est;
         rem_in = diff[DVSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_go_ff <= 1'b0;
         sub_go_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         mul_go_ff <= mul_go_in;
         sub_go_ff <= sub_go_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/cca_datapath.sv
module cca_datapath
   import cca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   output logic [RSP_W-1:0] rsp_tdata
);

   op_type              op_ff, op_in;
   logic [15:0]         ld_year_ff, ld_year_in;
   logic [7:0]          ld_month_ff, ld_month_in;
   logic [7:0]          ld_day_ff, ld_day_in;
   logic [7:0]          ld_hour_ff, ld_hour_in;
   logic [7:0]          ld_minute_ff, ld_minute_in;
   logic [7:0]          ld_second_ff, ld_second_in;
   logic [31:0]         ld_micro_ff, ld_micro_in;
   logic [31:0]         amount_ff, amount_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic [DAY_W-1:0]    day_ff, day_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MIN_W-1:0]    minute_ff, minute_in;
   logic [SEC_W-1:0]    second_ff, second_in;
   logic [MICRO_W-1:0]  micro_ff, micro_in;
   logic                set_ff, set_in;

   logic [YEAR_W-1:0]   cl_year;
   logic [MONTH_W-1:0]  cl_month;
   logic [DAY_W-1:0]    cl_dim;
   logic [DAY_W-1:0]    cl_day;
   logic [HOUR_W-1:0]   cl_hour;
   logic [MIN_W-1:0]    cl_minute;
   logic [SEC_W-1:0]    cl_second;
   logic [MICRO_W-1:0]  cl_micro;
   logic [DAY_W-1:0]    cur_dim;

   logic                div_done;
   logic [ACC_W-1:0]    div_quo;
   logic [DVSR_W-1:0]   div_rem;

   cca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (acc_ff),
      .sel       (cmd.div_sel),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // load clamps
   always_comb begin
      if (ld_year_ff < 16'(YEAR_MIN)) begin
         cl_year = YEAR_MIN;
      end else if (ld_year_ff > 16'(YEAR_MAX)) begin
         cl_year = YEAR_MAX;
      end else begin
         cl_year = ld_year_ff[YEAR_W-1:0];
      end
      if (ld_month_ff < 8'(MONTH_FIRST)) begin
         cl_month = MONTH_FIRST;
      end else if (ld_month_ff > 8'(MONTH_LAST)) begin
         cl_month = MONTH_LAST;
      end else begin
         cl_month = ld_month_ff[MONTH_W-1:0];
      end
      cl_dim = month_days(cl_year, cl_month);
      if (ld_day_ff < 8'(DAY_FIRST)) begin
         cl_day = DAY_FIRST;
      end else if (ld_day_ff > 8'(cl_dim)) begin
         cl_day = cl_dim;
      end else begin
         cl_day = ld_day_ff[DAY_W-1:0];
      end
      cl_hour   = (ld_hour_ff > 8'(HOUR_LAST)) ? HOUR_LAST : ld_hour_ff[HOUR_W-1:0];
      cl_minute = (ld_minute_ff > 8'(MIN_LAST)) ? MIN_LAST : ld_minute_ff[MIN_W-1:0];
      cl_second = (ld_second_ff > 8'(SEC_LAST)) ? SEC_LAST : ld_second_ff[SEC_W-1:0];
      cl_micro  = (ld_micro_ff > 32'(MICRO_LAST)) ? MICRO_LAST
                                                 : ld_micro_ff[MICRO_W-1:0];
   end

   assign cur_dim        = month_days(year_ff, month_ff);
   assign sts.op         = op_ff;
   assign sts.div_done   = div_done;
   assign sts.month_more = (acc_ff > ACC_W'(cur_dim));
   assign sts.month_sat  = (month_ff == MONTH_LAST) && (year_ff == YEAR_MAX);

   always_comb begin
      op_in        = op_ff;
      ld_year_in   = ld_year_ff;
      ld_month_in  = ld_month_ff;
      ld_day_in    = ld_day_ff;
      ld_hour_in   = ld_hour_ff;
      ld_minute_in = ld_minute_ff;
      ld_second_in = ld_second_ff;
      ld_micro_in  = ld_micro_ff;
      amount_in    = amount_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      micro_in     = micro_ff;
      set_in       = set_ff;

      if (cmd.capture) begin
         op_in        = op_type'(req_tuser);
         ld_year_in   = req_tdata[15:0];
         ld_month_in  = req_tdata[23:16];
         ld_day_in    = req_tdata[31:24];
         ld_hour_in   = req_tdata[39:32];
         ld_minute_in = req_tdata[47:40];
         ld_second_in = req_tdata[55:48];
         ld_micro_in  = req_tdata[87:56];
         amount_in    = req_tdata[119:88];
      end

      if (cmd.load) begin
         year_in   = cl_year;
         month_in  = cl_month;
         day_in    = cl_day;
         hour_in   = cl_hour;
         minute_in = cl_minute;
         second_in = cl_second;
         micro_in  = cl_micro;
         set_in    = 1'b1;
      end

      if (cmd.acc_init) begin
         if (op_ff == OP_MICRO) begin
            acc_in = ACC_W'(micro_ff) + ACC_W'(amount_ff);
         end else begin
            acc_in = ACC_W'(second_ff) + ACC_W'(amount_ff);
         end
      end

      // remainder stays in the field, quotient carries into the next one
      if (cmd.div_take) begin
         case (cmd.div_sel)
            DIV_US: begin
               micro_in = div_rem[MICRO_W-1:0];
               acc_in   = div_quo + ACC_W'(second_ff);
            end
            DIV_SEC: begin
               second_in = div_rem[SEC_W-1:0];
               acc_in    = div_quo + ACC_W'(minute_ff);
            end
            DIV_MIN: begin
               minute_in = div_rem[MIN_W-1:0];
               acc_in    = div_quo + ACC_W'(hour_ff);
            end
            DIV_HOUR: begin
               hour_in = div_rem[HOUR_W-1:0];
               acc_in  = div_quo + ACC_W'(day_ff);
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      if (cmd.month_step) begin
         acc_in = acc_ff - ACC_W'(cur_dim);
         if (month_ff == MONTH_LAST) begin
            if (year_ff == YEAR_MAX) begin
               month_in  = MONTH_LAST;
               day_in    = DAY_LAST;
               hour_in   = HOUR_LAST;
               minute_in = MIN_LAST;
               second_in = SEC_LAST;
               micro_in  = MICRO_LAST;
            end else begin
               month_in = MONTH_FIRST;
               year_in  = year_ff + 1'b1;
            end
         end else begin
            month_in = month_ff + 1'b1;
         end
      end

      if (cmd.month_end) begin
         day_in = acc_ff[DAY_W-1:0];
      end

      if (cmd.publish) begin
         rsp_data_in = {3'b000, set_ff, micro_ff, second_ff, minute_ff, hour_ff,
                        day_ff, month_ff, year_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= '0;
         month_ff  <= MONTH_FIRST;
         day_ff    <= DAY_FIRST;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         micro_ff  <= '0;
         set_ff    <= 1'b0;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         micro_ff  <= micro_in;
         set_ff    <= set_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ld_year_ff   <= ld_year_in;
      ld_month_ff  <= ld_month_in;
      ld_day_ff    <= ld_day_in;
      ld_hour_ff   <= ld_hour_in;
      ld_minute_ff <= ld_minute_in;
      ld_second_ff <= ld_second_in;
      ld_micro_ff  <= ld_micro_in;
      amount_ff    <= amount_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: rtl/cca_ctrl.sv
module cca_ctrl
   import cca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_LOAD:  state_in = ST_PUBLISH;
               OP_MICRO: state_in = ST_US_GO;
               OP_SEC:   state_in = ST_SEC_GO;
               default:  state_in = ST_PUBLISH;
            endcase
         end
         ST_US_GO:   state_in = ST_US_WAIT;
         ST_US_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_SEC_GO;
            end
         end
         ST_SEC_GO:   state_in = ST_SEC_WAIT;
         ST_SEC_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MIN_GO;
            end
         end
         ST_MIN_GO:   state_in = ST_MIN_WAIT;
         ST_MIN_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_HOUR_GO;
            end
         end
         ST_HOUR_GO:   state_in = ST_HOUR_WAIT;
         ST_HOUR_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (!sts.month_more || sts.month_sat) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = cmd_type'('0);
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            cmd.load     = (sts.op == OP_LOAD);
            cmd.acc_init = (sts.op == OP_MICRO) || (sts.op == OP_SEC);
         end
         ST_US_GO: begin
            cmd.div_sel   = DIV_US;
            cmd.div_start = 1'b1;
         end
         ST_US_WAIT: begin
            cmd.div_sel  = DIV_US;
            cmd.div_take = sts.div_done;
         end
         ST_SEC_GO: begin
            cmd.div_sel   = DIV_SEC;
            cmd.div_start = 1'b1;
         end
         ST_SEC_WAIT: begin
            cmd.div_sel  = DIV_SEC;
            cmd.div_take = sts.div_done;
         end
         ST_MIN_GO: begin
            cmd.div_sel   = DIV_MIN;
            cmd.div_start = 1'b1;
         end
         ST_MIN_WAIT: begin
            cmd.div_sel  = DIV_MIN;
            cmd.div_take = sts.div_done;
         end
         ST_HOUR_GO: begin
            cmd.div_sel   = DIV_HOUR;
            cmd.div_start = 1'b1;
         end
         ST_HOUR_WAIT: begin
            cmd.div_sel  = DIV_HOUR;
            cmd.div_take = sts.div_done;
         end
         ST_MONTH: begin
            cmd.month_step = sts.month_more;
            cmd.month_end  = !sts.month_more;
         end
         ST_PUBLISH: begin
            cmd.publish = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/calendar_clock_accumulator.sv
// channel  dir  tdata                                        tuser
// req      in   load_year, load_month, load_day, load_hour,  operation
//               load_minute, load_second, load_micro, amount
// rsp      out  cur_year, cur_month, cur_day, cur_hour,      -
//               cur_minute, cur_second, cur_micro, is_set
//
// One request at a time. A load passes decode, then publish, for its result.
// Microsecond advance divides microseconds, seconds, minutes and hours in turn;
// second advance starts at seconds. Each field goes through the shared reciprocal
// divider; the day carry then walks one month a cycle (up to about 1600 months).
// Synchronous reset gives 0000-01-01 00:00:00.000000, not set.
// The result is held in an output register; the next request is taken while
// it waits, but a further result waits for the held one to be taken.
module calendar_clock_accumulator
   import cca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // load_year, load_month, load_day, load_hour, load_minute, load_second,
   // load_micro, amount
   input  logic [REQ_W-1:0] req_tdata,
   // operation
   input  logic [OP_W-1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
   // cur_micro, is_set, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   cca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cca_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: rtl/cca_checker.sv
module cca_checker
   import cca_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // result year at most YEAR_MAX, month 1 to 12, day at least 1, time fields in range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[13:0] <= YEAR_MAX) &&
         (rsp_tdata[17:14] >= MONTH_FIRST) && (rsp_tdata[17:14] <= MONTH_LAST) &&
         (rsp_tdata[22:18] >= DAY_FIRST) &&
         (rsp_tdata[27:23] <= HOUR_LAST) &&
         (rsp_tdata[33:28] <= MIN_LAST) &&
         (rsp_tdata[39:34] <= SEC_LAST) &&
         (rsp_tdata[59:40] <= MICRO_LAST))
      else $error("result field out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while idle");

endmodule

bind calendar_clock_accumulator cca_checker u_cca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
